>>> sv/drd_pkg.sv
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the detector row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int BOX_FIELDS  = 4;
    localparam int BOX_IDX_W   = 2;
    localparam int ROW_LEN     = BOX_FIELDS + NUM_CLASSES;
    localparam int IDX_W       = $clog2(ROW_LEN);

    localparam int VAL_W    = 24;   // Q12.12 row element
    localparam int CLASS_W  = 8;
    localparam int THR_W    = 13;
    localparam int SCALE_W  = 24;   // Q8.16
    localparam int PAD_W    = 12;
    localparam int SIZE_W   = 14;
    localparam int POS_W    = 13;   // left / top
    localparam int CORNER_W = 14;   // right / bottom

    // corner in Q.13: 2*c +/- s - pad*8192 stays within +/- 2^26
    localparam int Q_W        = 27;
    localparam int MAG_W      = Q_W - 1;
    localparam int PROD_W     = MAG_W + SCALE_W;
    localparam int FRAC_SHIFT = 29;
    localparam int RMAG_W     = PROD_W - FRAC_SHIFT;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [SIZE_W-1:0] FRAME_MAX  = SIZE_W'(8192);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_THRESHOLD = 3'd0,
        CFG_INV_SCALE      = 3'd1,
        CFG_PAD_X          = 3'd2,
        CFG_PAD_Y          = 3'd3,
        CFG_FRAME_WIDTH    = 3'd4,
        CFG_FRAME_HEIGHT   = 3'd5
    } cfg_reg_t;

    localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(1024);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(65536);
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(1080);

    // one finished row that passed the threshold
    typedef struct packed {
        logic signed [Q_W-1:0] q_left;
        logic signed [Q_W-1:0] q_top;
        logic signed [Q_W-1:0] q_right;
        logic signed [Q_W-1:0] q_bottom;
        logic [CLASS_W-1:0]    label;
        logic [VAL_W-1:0]      score;
    } row_rec_t;

endpackage

>>> sv/drd_row_track.sv
// ----------------------------------------------------------------------------
// drd_row_track
// Row position, box capture and running argmax; forms the Q.13 corners of a
// row that passes the threshold.
// ----------------------------------------------------------------------------
module drd_row_track (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           i_valid,
    output logic                           i_ready,
    input  logic [drd_pkg::VAL_W-1:0]      i_value,
    input  logic [drd_pkg::THR_W-1:0]      conf_threshold,
    input  logic [drd_pkg::PAD_W-1:0]      pad_x,
    input  logic [drd_pkg::PAD_W-1:0]      pad_y,
    output logic                           o_valid,
    input  logic                           o_ready,
    output drd_pkg::row_rec_t              o_rec
);

    logic [drd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [drd_pkg::VAL_W-1:0]   box_reg [drd_pkg::BOX_FIELDS];
    logic [drd_pkg::VAL_W-1:0]   best_score_reg, best_score_next;
    logic [drd_pkg::CLASS_W-1:0] best_class_reg, best_class_next;
    logic                        found_reg, found_next;
    logic                        o_valid_reg, o_valid_next;
    drd_pkg::row_rec_t           rec_reg, rec_next;

    logic                        take;
    logic                        is_box;
    logic                        is_last;
    logic                        gt;
    logic                        emit;
    logic [drd_pkg::VAL_W-1:0]   cand_score;
    logic [drd_pkg::CLASS_W-1:0] cand_class;
    logic                        cand_found;

    function automatic logic signed [drd_pkg::Q_W-1:0] corner_q(
        input logic [drd_pkg::VAL_W-1:0] c,
        input logic [drd_pkg::VAL_W-1:0] s,
        input logic                      plus,
        input logic [drd_pkg::PAD_W-1:0] pad
    );
        logic signed [drd_pkg::Q_W-1:0] base;
        logic signed [drd_pkg::Q_W-1:0] sz;
        base = $signed({2'b00, c, 1'b0}) - $signed({2'b00, pad, 13'b0});
        sz   = $signed({3'b000, s});
        return plus ? base + sz : base - sz;
    endfunction

    assign i_ready = !o_valid_reg || o_ready;
    assign take    = i_valid && i_ready;
    assign is_box  = idx_reg < drd_pkg::IDX_W'(drd_pkg::BOX_FIELDS);
    assign is_last = idx_reg == drd_pkg::IDX_W'(drd_pkg::ROW_LEN - 1);
    assign gt      = i_value > best_score_reg;

    always_comb begin
        cand_score = gt ? i_value : best_score_reg;
        cand_class = gt ? drd_pkg::CLASS_W'(idx_reg - drd_pkg::IDX_W'(drd_pkg::BOX_FIELDS))
                        : best_class_reg;
        cand_found = found_reg || gt;
        emit       = is_last && cand_found
                     && (cand_score >= drd_pkg::VAL_W'(conf_threshold));
    end

    always_comb begin
        idx_next        = idx_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        found_next      = found_reg;
        if (take) begin
            if (is_last) begin
                idx_next        = '0;
                best_score_next = '0;
                best_class_next = '0;
                found_next      = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (!is_box) begin
                    best_score_next = cand_score;
                    best_class_next = cand_class;
                    found_next      = cand_found;
                end
            end
        end
    end

    always_comb begin
        o_valid_next = o_valid_reg;
        rec_next     = rec_reg;
        if (take && emit) begin
            o_valid_next      = 1'b1;
            rec_next.q_left   = corner_q(box_reg[0], box_reg[2], 1'b0, pad_x);
            rec_next.q_top    = corner_q(box_reg[1], box_reg[3], 1'b0, pad_y);
            rec_next.q_right  = corner_q(box_reg[0], box_reg[2], 1'b1, pad_x);
            rec_next.q_bottom = corner_q(box_reg[1], box_reg[3], 1'b1, pad_y);
            rec_next.label    = cand_class;
            rec_next.score    = cand_score;
        end else if (o_ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            found_reg      <= 1'b0;
            o_valid_reg    <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            found_reg      <= found_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        if (take && is_box) begin
            box_reg[idx_reg[drd_pkg::BOX_IDX_W-1:0]] <= i_value;
        end
    end

    assign o_valid = o_valid_reg;
    assign o_rec   = rec_reg;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= drd_pkg::IDX_W'(drd_pkg::ROW_LEN - 1))
        else $error("row position past end of row");

    a_no_best_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (best_score_reg == '0))
        else $error("best score set without a winning class");

    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && is_last |=> (idx_reg == '0) && !found_reg)
        else $error("row state not cleared after last score");
`endif

endmodule

>>> sv/drd_corner.sv
// ----------------------------------------------------------------------------
// drd_corner
// One corner lane: scale by inv_scale, round half away from zero, clamp.
// ----------------------------------------------------------------------------
module drd_corner (
    input  logic                               aclk,
    input  logic                               en_mul,
    input  logic                               en_clamp,
    input  logic signed [drd_pkg::Q_W-1:0]     q,
    input  logic [drd_pkg::SCALE_W-1:0]        inv_scale,
    input  logic [drd_pkg::SIZE_W-1:0]         size,
    output logic [drd_pkg::POS_W-1:0]          px
);

    logic [drd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       neg_reg;
    logic [drd_pkg::POS_W-1:0]  px_reg, px_next;

    logic [drd_pkg::Q_W-1:0]    q_abs;
    logic [drd_pkg::PROD_W-1:0] rounded;
    logic [drd_pkg::RMAG_W-1:0] rmag;
    logic [drd_pkg::SIZE_W-1:0] size_c;
    logic [drd_pkg::POS_W-1:0]  limit;

    always_comb begin
        q_abs     = q[drd_pkg::Q_W-1] ? drd_pkg::Q_W'(-q) : drd_pkg::Q_W'(q);
        prod_next = q_abs[drd_pkg::MAG_W-1:0] * inv_scale;
    end

    always_comb begin
        rounded = prod_reg + drd_pkg::ROUND_HALF;
        rmag    = rounded[drd_pkg::PROD_W-1:drd_pkg::FRAC_SHIFT];
        size_c  = (size > drd_pkg::FRAME_MAX) ? drd_pkg::FRAME_MAX : size;
        limit   = (size_c == '0) ? '0 : drd_pkg::POS_W'(size_c - 1'b1);
        // negative corners round toward or below zero, both clamp to zero
        if (neg_reg) begin
            px_next = '0;
        end else if (rmag > drd_pkg::RMAG_W'(limit)) begin
            px_next = limit;
        end else begin
            px_next = drd_pkg::POS_W'(rmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_reg <= prod_next;
            neg_reg  <= q[drd_pkg::Q_W-1];
        end
        if (en_clamp) begin
            px_reg <= px_next;
        end
    end

    assign px = px_reg;

endmodule

>>> sv/detector_row_decode.sv
// ----------------------------------------------------------------------------
// detector_row_decode
// Streams detector output rows and emits one frame-space detection per row.
// ----------------------------------------------------------------------------
// Input channel s_*: one Q12.12 row element per beat; a row is centre x,
// centre y, width, height, then NUM_CLASSES class scores, rows back to back.
// Output channel m_*: at most one detection beat per row (box corners in
// frame pixels, winning class and score); nothing when no class scored above
// zero or the best score is under conf_threshold.
// Config channel cfg_*: register writes by index, always ready; write only
// while no row is in flight.
// Throughput: one element per cycle while m_ready does not stall the output.
// After the row's last score is accepted, its detection passes through the
// input register, argmax, multiply, round/clamp and output register.
// When m_ready is low the pipeline holds; s_ready drops once the stages
// behind the output register are full, so no beat is lost.
// Reset clears the row position and argmax, empties the pipeline and loads
// the register defaults (threshold 1.0/4, unit scale, no pad, 1920x1080).
// ----------------------------------------------------------------------------
module detector_row_decode (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [drd_pkg::VAL_W-1:0]         s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [drd_pkg::POS_W-1:0]         m_left,
    output logic [drd_pkg::POS_W-1:0]         m_top,
    output logic [drd_pkg::CORNER_W-1:0]      m_right,
    output logic [drd_pkg::CORNER_W-1:0]      m_bottom,
    output logic [drd_pkg::CLASS_W-1:0]       m_label,
    output logic [drd_pkg::VAL_W-1:0]         m_score,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [drd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic [drd_pkg::THR_W-1:0]   conf_threshold_reg;
    logic [drd_pkg::SCALE_W-1:0] inv_scale_reg;
    logic [drd_pkg::PAD_W-1:0]   pad_x_reg;
    logic [drd_pkg::PAD_W-1:0]   pad_y_reg;
    logic [drd_pkg::SIZE_W-1:0]  frame_width_reg;
    logic [drd_pkg::SIZE_W-1:0]  frame_height_reg;

    // input register
    logic                        in_vld_reg, in_vld_next;
    logic [drd_pkg::VAL_W-1:0]   in_value_reg;

    // pipeline
    logic                        row_ready;
    logic                        row_valid;
    drd_pkg::row_rec_t           row_rec;
    logic                        v2_reg, v2_next;
    logic                        v3_reg, v3_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        load2, load3, load_out;
    logic                        st2_free, st3_free, out_free;
    logic [drd_pkg::CLASS_W-1:0] class2_reg, class3_reg;
    logic [drd_pkg::VAL_W-1:0]   score2_reg, score3_reg;
    logic [drd_pkg::POS_W-1:0]   px_l, px_t, px_r, px_b;
    logic [drd_pkg::CORNER_W-1:0] l_plus1, t_plus1, r_ext, b_ext;

    logic [drd_pkg::POS_W-1:0]    left_reg, top_reg;
    logic [drd_pkg::CORNER_W-1:0] right_reg, bottom_reg;
    logic [drd_pkg::CLASS_W-1:0]  class_out_reg;
    logic [drd_pkg::VAL_W-1:0]    score_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_threshold_reg <= drd_pkg::THR_RESET;
            inv_scale_reg      <= drd_pkg::SCALE_RESET;
            pad_x_reg          <= '0;
            pad_y_reg          <= '0;
            frame_width_reg    <= drd_pkg::WIDTH_RESET;
            frame_height_reg   <= drd_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                drd_pkg::CFG_CONF_THRESHOLD: conf_threshold_reg <= cfg_data[drd_pkg::THR_W-1:0];
                drd_pkg::CFG_INV_SCALE:      inv_scale_reg      <= cfg_data[drd_pkg::SCALE_W-1:0];
                drd_pkg::CFG_PAD_X:          pad_x_reg          <= cfg_data[drd_pkg::PAD_W-1:0];
                drd_pkg::CFG_PAD_Y:          pad_y_reg          <= cfg_data[drd_pkg::PAD_W-1:0];
                drd_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[drd_pkg::SIZE_W-1:0];
                drd_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[drd_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign s_ready     = !in_vld_reg || row_ready;
    assign in_vld_next = (s_valid && s_ready) || (in_vld_reg && !row_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_value;
        end
    end

    drd_row_track u_row_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .i_valid        (in_vld_reg),
        .i_ready        (row_ready),
        .i_value        (in_value_reg),
        .conf_threshold (conf_threshold_reg),
        .pad_x          (pad_x_reg),
        .pad_y          (pad_y_reg),
        .o_valid        (row_valid),
        .o_ready        (st2_free),
        .o_rec          (row_rec)
    );

    // stage control, back to front
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = v3_reg && out_free;
    assign st3_free = !v3_reg || load_out;
    assign load3    = v2_reg && st3_free;
    assign st2_free = !v2_reg || load3;
    assign load2    = row_valid && st2_free;

    always_comb begin
        v2_next      = load2 || (v2_reg && !load3);
        v3_next      = load3 || (v3_reg && !load_out);
        m_valid_next = load_out || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    drd_corner u_corner_left (
        .aclk (aclk), .en_mul (load2), .en_clamp (load3),
        .q (row_rec.q_left), .inv_scale (inv_scale_reg),
        .size (frame_width_reg), .px (px_l)
    );

    drd_corner u_corner_top (
        .aclk (aclk), .en_mul (load2), .en_clamp (load3),
        .q (row_rec.q_top), .inv_scale (inv_scale_reg),
        .size (frame_height_reg), .px (px_t)
    );

    drd_corner u_corner_right (
        .aclk (aclk), .en_mul (load2), .en_clamp (load3),
        .q (row_rec.q_right), .inv_scale (inv_scale_reg),
        .size (frame_width_reg), .px (px_r)
    );

    drd_corner u_corner_bottom (
        .aclk (aclk), .en_mul (load2), .en_clamp (load3),
        .q (row_rec.q_bottom), .inv_scale (inv_scale_reg),
        .size (frame_height_reg), .px (px_b)
    );

    always_ff @(posedge aclk) begin
        if (load2) begin
            class2_reg <= row_rec.label;
            score2_reg <= row_rec.score;
        end
        if (load3) begin
            class3_reg <= class2_reg;
            score3_reg <= score2_reg;
        end
    end

    // far corners are kept at least one pixel past the near ones
    always_comb begin
        l_plus1 = {1'b0, px_l} + 1'b1;
        t_plus1 = {1'b0, px_t} + 1'b1;
        r_ext   = {1'b0, px_r};
        b_ext   = {1'b0, px_b};
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            left_reg      <= px_l;
            top_reg       <= px_t;
            right_reg     <= (r_ext < l_plus1) ? l_plus1 : r_ext;
            bottom_reg    <= (b_ext < t_plus1) ? t_plus1 : b_ext;
            class_out_reg <= class3_reg;
            score_out_reg <= score3_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_left     = left_reg;
    assign m_top      = top_reg;
    assign m_right    = right_reg;
    assign m_bottom   = bottom_reg;
    assign m_label    = class_out_reg;
    assign m_score    = score_out_reg;

`ifndef NO_ASSERTIONS
    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_right > {1'b0, m_left}) && (m_bottom > {1'b0, m_top}))
        else $error("far corner not past near corner");

    a_score_threshold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_score >= drd_pkg::VAL_W'(conf_threshold_reg)) && (m_score != '0))
        else $error("detection below threshold emitted");

    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_right <= drd_pkg::FRAME_MAX) && (m_bottom <= drd_pkg::FRAME_MAX))
        else $error("corner outside largest frame");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !out_free |=> v3_reg && $stable(score3_reg))
        else $error("clamp stage lost a detection under stall");
`endif

endmodule
